### rtl/core/slm_pkg.sv
// Shared types and codes for the backward sorted-list merge block.
// No dependencies.
package slm_pkg;

  localparam int DEPTH_DEF = 16;   // default list depth
  localparam int MAX_OUT   = 32;   // results emitted per merge at most

  localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [1:0] OP_MERGE         = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         position;
    logic signed [31:0] value_res;
    logic               from_second;
    logic               dropped;
    logic               last;
  } out_item_t;

endpackage

### rtl/core/sorted_list_merge_backward.sv
// Backward merge of two ascending lists; top level with list memories and sequencer.
// Depends on slm_pkg.
//
// Loads (append to first or second list) are taken one per cycle. A merge item
// then emits the merged list from the highest position down to 0, largest tail
// first, ties going to the first list. For each result, the read state reads both
// list tails from their memories and the select state compares them and loads the
// output register, waiting while the output stalls; the input stays stalled for
// the whole merge. A merge of two empty lists finishes in its accept cycle.
// At most MAX_OUT results leave per merge. Loads past DEPTH are discarded and
// flag the dropped bit on the next merge's results; counts and the flag clear
// when a merge ends.
module sorted_list_merge_backward #(
  parameter int DEPTH = slm_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  slm_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output slm_pkg::out_item_t out_item
);
  import slm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(2 * DEPTH + 1);
  localparam int KW = $clog2(MAX_OUT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_SEL  = 2'd2;

  logic [31:0] first_mem  [DEPTH];
  logic [31:0] second_mem [DEPTH];

  logic [1:0]  state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic        ovf_r, ovf_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r;
  logic signed [31:0] rd_a_r, rd_b_r;

  logic        in_acc, out_free, emit, take_a, done;
  logic [PW-1:0] pos_dec;
  logic [CW-1:0] cnt_a_dec, cnt_b_dec;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign cnt_a_dec = cnt_a_r - 1'b1;
  assign cnt_b_dec = cnt_b_r - 1'b1;
  assign pos_dec   = pos_r - 1'b1;
  assign take_a    = (cnt_a_r != '0) && ((cnt_b_r == '0) || (rd_a_r >= rd_b_r));
  assign emit      = (state_r == ST_SEL) && out_free;
  assign done      = (pos_dec == '0) || (k_r == KW'(MAX_OUT - 1));

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    pos_nxt       = pos_r;
    k_nxt         = k_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.op)
            OP_APPEND_FIRST: begin
              if (cnt_a_r < CW'(DEPTH)) cnt_a_nxt = cnt_a_r + 1'b1;
              else                      ovf_nxt   = 1'b1;
            end
            OP_APPEND_SECOND: begin
              if (cnt_b_r < CW'(DEPTH)) cnt_b_nxt = cnt_b_r + 1'b1;
              else                      ovf_nxt   = 1'b1;
            end
            OP_MERGE: begin
              pos_nxt = PW'(cnt_a_r) + PW'(cnt_b_r);
              k_nxt   = '0;
              if ((cnt_a_r == '0) && (cnt_b_r == '0)) begin
                ovf_nxt = 1'b0;
              end else begin
                state_nxt = ST_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: state_nxt = ST_SEL;
      ST_SEL: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_dec;
          k_nxt         = k_r + 1'b1;
          if (take_a) cnt_a_nxt = cnt_a_dec;
          else        cnt_b_nxt = cnt_b_dec;
          if (done) begin
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      pos_r       <= '0;
      k_r         <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      pos_r       <= pos_nxt;
      k_r         <= k_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // List memories: one write port for loads, one read port each for the tail.
  always_ff @(posedge clk) begin
    if (in_acc && (in_item.op == OP_APPEND_FIRST) && (cnt_a_r < CW'(DEPTH)))
      first_mem[cnt_a_r[AW-1:0]] <= in_item.value;
    if (in_acc && (in_item.op == OP_APPEND_SECOND) && (cnt_b_r < CW'(DEPTH)))
      second_mem[cnt_b_r[AW-1:0]] <= in_item.value;
  end

  // Tail reads; an empty list's read is don't-care and masked by take_a.
  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      rd_a_r <= first_mem[cnt_a_dec[AW-1:0]];
      rd_b_r <= second_mem[cnt_b_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.position    <= 5'(pos_dec);
      out_item_r.value_res   <= take_a ? rd_a_r : rd_b_r;
      out_item_r.from_second <= !take_a;
      out_item_r.dropped     <= ovf_r;
      out_item_r.last        <= (pos_dec == '0);
    end
  end

endmodule

### verif/slm_merge_checker.sv
// Passive checker for the backward sorted-list merge: tracks both lists from the
// accepted input items, predicts every merged element and compares the results.
// Depends on slm_pkg.
module slm_merge_checker #(
  parameter int DEPTH = slm_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  slm_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  slm_pkg::out_item_t out_item,
  output int                 errors,
  output int                 pending,
  output int                 checked,
  output int                 dropped_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import slm_pkg::*;

  logic signed [31:0] first_vals  [DEPTH];
  logic signed [31:0] second_vals [DEPTH];
  int                 first_len;
  int                 second_len;
  logic               overflow;
  out_item_t          merged_q [$];

  initial begin
    errors       = 0;
    pending      = 0;
    checked      = 0;
    dropped_seen = 0;
  end

  // Walk both tails from the back, larger tail first, ties to the first list.
  task automatic merge_lists();
    int        i;
    int        j;
    int        pos;
    int        k;
    bit        take_first;
    out_item_t res;
    i   = first_len;
    j   = second_len;
    pos = i + j;
    k   = 0;
    while (pos > 0 && k < MAX_OUT) begin
      pos--;
      if (i == 0)
        take_first = 1'b0;
      else if (j == 0)
        take_first = 1'b1;
      else
        take_first = (first_vals[i-1] >= second_vals[j-1]);
      res.position = pos[4:0];
      if (take_first) begin
        i--;
        res.value_res   = first_vals[i];
        res.from_second = 1'b0;
      end else begin
        j--;
        res.value_res   = second_vals[j];
        res.from_second = 1'b1;
      end
      res.dropped = overflow;
      res.last    = (pos == 0);
      merged_q.push_back(res);
      k++;
    end
    first_len  = 0;
    second_len = 0;
    overflow   = 1'b0;
  endtask

  task automatic absorb_item(in_item_t it);
    case (it.op)
      OP_APPEND_FIRST: begin
        if (first_len < DEPTH) begin
          first_vals[first_len] = it.value;
          first_len++;
        end else begin
          overflow = 1'b1;
        end
      end
      OP_APPEND_SECOND: begin
        if (second_len < DEPTH) begin
          second_vals[second_len] = it.value;
          second_len++;
        end else begin
          overflow = 1'b1;
        end
      end
      OP_MERGE: merge_lists();
      default: ;  // unused code leaves the lists alone
    endcase
  endtask

  task automatic compare_result(out_item_t got);
    out_item_t want;
    if (merged_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result pos=%0d val=%0d src=%0b drop=%0b last=%0b",
                 $realtime, got.position, got.value_res, got.from_second,
                 got.dropped, got.last);
      return;
    end
    want = merged_q.pop_front();
    checked++;
    if (got.dropped === 1'b1)
      dropped_seen++;
    if (got.position !== want.position || got.value_res !== want.value_res ||
        got.from_second !== want.from_second || got.dropped !== want.dropped ||
        got.last !== want.last) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch exp pos=%0d val=%0d src=%0b drop=%0b last=%0b | got pos=%0d val=%0d src=%0b drop=%0b last=%0b",
                 $realtime, want.position, want.value_res, want.from_second,
                 want.dropped, want.last, got.position, got.value_res,
                 got.from_second, got.dropped, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      first_len  = 0;
      second_len = 0;
      overflow   = 1'b0;
      merged_q.delete();
    end else begin
      if (in_valid && !in_stall)
        absorb_item(in_item);
      if (out_valid && !out_stall)
        compare_result(out_item);
    end
    pending = merged_q.size();
  end

endmodule

### verif/tb.sv
// Top of the merge testbench: clock, reset, stimulus with random idling on both
// channels and the final verdict. Depends on slm_pkg, sorted_list_merge_backward
// and slm_merge_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         N_ITEMS   = 180;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int errors;
  int pending;
  int checked;
  int dropped_seen;
  int items_sent = 0;
  int merges_sent = 0;
  bit quiet = 1'b1;

  always #5 clk = ~clk;

  sorted_list_merge_backward dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  slm_merge_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .dropped_seen (dropped_seen)
  );

  always @(negedge clk)
    out_stall <= !quiet && ($urandom_range(0, 99) < 11);

  task automatic send_item(logic [1:0] op, int v);
    in_item_t it;
    it.op    = op;
    it.value = v;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (op != OP_UNUSED)
      items_sent++;
    if (op == OP_MERGE)
      merges_sent++;
  endtask

  // Next list element; sorted lists climb from a low start and saturate at the top.
  function automatic int next_value(int prev, bit first_elem, bit narrow, bit sorted);
    longint nxt;
    if (!sorted)
      return narrow ? int'($urandom_range(0, 12)) - 6 : int'($urandom);
    if (first_elem)
      return narrow ? int'($urandom_range(0, 8)) - 8
                    : (int'($urandom) >>> 1) - 32'sh4000_0000;
    nxt = longint'(prev) +
          longint'(narrow ? $urandom_range(0, 2) : $urandom_range(0, 32'h1000_0000));
    if (nxt > 64'sd2147483647)
      nxt = 64'sd2147483647;
    return int'(nxt);
  endfunction

  // Load both lists in random interleaving, then merge.
  task automatic run_sequence(int na, int nb, bit narrow, bit sorted);
    int firsts [$];
    int seconds [$];
    int prev;
    prev = 0;
    for (int k = 0; k < na; k++) begin
      prev = next_value(prev, k == 0, narrow, sorted);
      firsts.push_back(prev);
    end
    for (int k = 0; k < nb; k++) begin
      prev = next_value(prev, k == 0, narrow, sorted);
      seconds.push_back(prev);
    end
    while (firsts.size() != 0 || seconds.size() != 0) begin
      if (seconds.size() == 0 || (firsts.size() != 0 && $urandom_range(0, 1)))
        send_item(OP_APPEND_FIRST, firsts.pop_front());
      else
        send_item(OP_APPEND_SECOND, seconds.pop_front());
    end
    send_item(OP_MERGE, int'($urandom));
  endtask

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int kind;
    int waited;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty merge, unused code, extremes with ties, first-list overflow.
    send_item(OP_MERGE, 32'sh7fff_ffff);
    send_item(OP_UNUSED, int'($urandom));
    send_item(OP_APPEND_FIRST, 32'sh8000_0000);
    send_item(OP_APPEND_SECOND, 32'sh8000_0000);
    send_item(OP_APPEND_FIRST, 0);
    send_item(OP_APPEND_SECOND, 32'sh7fff_ffff);
    send_item(OP_APPEND_FIRST, 32'sh7fff_ffff);
    send_item(OP_MERGE, 0);
    for (int k = 0; k <= slm_pkg::DEPTH_DEF; k++)
      send_item(OP_APPEND_FIRST, k - 8);
    send_item(OP_MERGE, -1);

    quiet = 1'b0;
    while (items_sent < N_ITEMS) begin
      quiet = (items_sent >= 80 && items_sent < 125);
      kind  = $urandom_range(0, 99);
      if (kind < 70)
        run_sequence($urandom_range(0, 9) == 0 ? $urandom_range(0, 16) : $urandom_range(0, 6),
                     $urandom_range(0, 9) == 0 ? $urandom_range(0, 16) : $urandom_range(0, 6),
                     1'($urandom_range(0, 1)), 1'b1);
      else if (kind < 76)
        run_sequence(16 + $urandom_range(0, 2), 16 + $urandom_range(0, 2),
                     1'($urandom_range(0, 1)), 1'b1);
      else if (kind < 88)
        run_sequence($urandom_range(0, 6), $urandom_range(0, 6),
                     1'($urandom_range(0, 1)), 1'b0);
      else
        repeat ($urandom_range(1, 4))
          send_item(2'($urandom_range(0, 3)), int'($urandom));
    end
    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b1;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);

    $display("covered %0d items with %0d merges;", items_sent, merges_sent);
    $display("%0d merged elements checked, %0d flagged dropped", checked, dropped_seen);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
